// ----- rtl/mwat_pkg.sv -----
// shared constants and types for the minimum window length block
package mwat_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned THR_W   = 32;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned SUM_W   = VAL_W + ADDR_W + 1;
  localparam int unsigned CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (32'(len) > 32'(LEN_MAX)) begin
      res = LEN_W'(LEN_MAX);
    end else begin
      res = LEN_W'(len);
    end
    return res;
  endfunction

endpackage

// ----- rtl/mwat_ram.sv -----
// single write port, single registered read port window store
module mwat_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mwat_alu.sv -----
// shared sum adder/subtractor and threshold comparator
module mwat_alu import mwat_pkg::*; (
  input  alu_op_e          op_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [VAL_W-1:0] operand_i,
  input  logic [THR_W-1:0] threshold_i,
  output logic [SUM_W-1:0] result_o,
  output logic             ge_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: result_o = sum_i + SUM_W'(operand_i);
      ALU_SUB: result_o = sum_i - SUM_W'(operand_i);
      default: result_o = sum_i;
    endcase
  end

  assign ge_o = CMP_W'(sum_i) >= CMP_W'(threshold_i);

endmodule

// ----- rtl/min_window_length_at_threshold.sv -----
// Shortest window whose sum reaches a threshold, over a stream of arrays.
// Input channel (in_valid_i/in_ready_o): one value per transfer, last_i marks
// the final element of an array. Output channel (out_valid_o/out_ready_i):
// exactly one result per input transfer, in order: best length so far (0 if
// none), sticky overflow flag and is_final as a copy of last.
// The threshold register is written via cfg_we_i/cfg_wdata_i; the user must
// do so only while idle (unenforced); it resets to 1 and survives array ends.
// One item at a time goes through a sequencer around one shared adder and
// comparator and a 1024-entry store with a registered read port.
// Each item passes S_IDLE, then S_DROP if the window was full and the oldest
// value is dropped, S_PUSH, S_CHECK, one S_POP and one more S_CHECK per value
// popped from the front for this item (each pop reads the store and subtracts)
// and S_DONE; out_valid_o rises when S_DONE loads the output register.
// Amortized over an array each value is popped at most once.
// in_ready_o is high only while the sequencer is idle. A finished result sits
// in the output register; the next item may be taken meanwhile, and its
// result waits in the sequencer until the receiver takes the previous one.
// Reset clears the window, best length and overflow flag; the store content
// is left as is and never read before being written. After a transfer with
// last set, all window state clears for the next array.
module min_window_length_at_threshold import mwat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [VAL_W-1:0] value_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LEN_W-1:0] best_len_o,
  output logic             window_overflow_o,
  output logic             is_final_o,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DROP  = 3'd1;
  localparam logic [2:0] S_PUSH  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [THR_W-1:0]  thr_q;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic              ovf_q, ovf_d;
  logic [VAL_W-1:0]  val_q;
  logic              last_q;
  logic              out_valid_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_ovf_q;
  logic              out_final_q;

  logic              in_xfer;
  logic              out_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_rdata;
  alu_op_e           alu_op;
  logic [VAL_W-1:0]  alu_operand;
  logic [SUM_W-1:0]  alu_result;
  logic              alu_ge;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign ram_waddr  = head_q + count_q[ADDR_W-1:0];
  assign ram_we     = (state_q == S_PUSH);

  mwat_ram #(
    .DATA_W (VAL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  mwat_alu u_alu (
    .op_i        (alu_op),
    .sum_i       (sum_q),
    .operand_i   (alu_operand),
    .threshold_i (thr_q),
    .result_o    (alu_result),
    .ge_o        (alu_ge)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    sum_d       = sum_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    out_load    = 1'b0;
    alu_op      = ALU_ADD;
    alu_operand = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (count_q == CNT_W'(DEPTH)) ? S_DROP : S_PUSH;
        end
      end
      S_DROP: begin
        alu_op      = ALU_SUB;
        alu_operand = ram_rdata;
        sum_d       = alu_result;
        head_d      = head_q + ADDR_W'(1);
        count_d     = count_q - CNT_W'(1);
        ovf_d       = 1'b1;
        state_d     = S_PUSH;
      end
      S_PUSH: begin
        alu_op  = ALU_ADD;
        sum_d   = alu_result;
        count_d = count_q + CNT_W'(1);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if ((count_q != '0) && alu_ge) begin
          if ((best_q == '0) || (count_q < best_q)) begin
            best_d = count_q;
          end
          state_d = S_POP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        alu_op      = ALU_SUB;
        alu_operand = ram_rdata;
        sum_d       = alu_result;
        head_d      = head_q + ADDR_W'(1);
        count_d     = count_q - CNT_W'(1);
        state_d     = S_CHECK;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (last_q) begin
            head_d  = '0;
            count_d = '0;
            sum_d   = '0;
            best_d  = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THR_W'(1);
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      best_q  <= best_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      val_q  <= value_i;
      last_q <= last_i;
    end
    if (out_load) begin
      out_len_q   <= sat_len(best_q);
      out_ovf_q   <= ovf_q;
      out_final_q <= last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign best_len_o        = out_len_q;
  assign window_overflow_o = out_ovf_q;
  assign is_final_o        = out_final_q;

endmodule
